FILE: hdl/cfe_pkg.sv
// shared types and constants for the cobs frame encoder
`timescale 1ns / 1ps
package cfe_pkg;

	localparam int MAX_RESULTS = 32;
	localparam int OUTQ_DEPTH  = 2;
	localparam int CMDQ_DEPTH  = 2;
	localparam logic [7:0] CODE_ONE = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} in_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        run_last;
		logic        frame_done;
	} out_t;

	// one release: code byte, len stored bytes, optional lone code 1
	typedef struct packed {
		logic       bank;
		logic [7:0] len;
		logic       tail_one;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

FILE: hdl/cfe_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module cfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hdl/cfe_fifo.sv
// small register fifo with occupancy count
`timescale 1ns / 1ps
module cfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign rdata = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

FILE: hdl/cfe_front.sv
// front end: accepts raw bytes, fills the open block and issues releases
`timescale 1ns / 1ps
module cfe_front #(
	parameter int MAX_BLOCK = 254,
	parameter int IW        = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cfe_pkg::in_t  item,
	output logic          ram_we,
	output logic [IW:0]   ram_waddr,
	output logic [7:0]    ram_wdata,
	output logic          cmd_push,
	output cfe_pkg::cmd_t cmd,
	input  logic          cmdq_full,
	input  cfe_pkg::rel_t rel
);
	import cfe_pkg::*;

	logic [7:0] cnt_q;
	logic       bank_q;
	logic [1:0] busy_q;
	logic       accept;
	logic       is_zero;
	logic [7:0] cnt_inc;
	logic       blk_full;
	logic       close_now;

	assign full      = cmdq_full || busy_q[bank_q];
	assign accept    = push && !full;
	assign is_zero   = (item.data_byte == 8'h00);
	assign cnt_inc   = cnt_q + 8'd1;
	assign blk_full  = !is_zero && (cnt_inc >= 8'(MAX_BLOCK));
	assign close_now = is_zero || blk_full || item.frame_last;

	assign ram_we    = accept && !is_zero;
	assign ram_waddr = {bank_q, cnt_q[IW-1:0]};
	assign ram_wdata = item.data_byte;

	assign cmd_push     = accept && close_now;
	assign cmd.bank     = bank_q;
	assign cmd.len      = is_zero ? cnt_q : cnt_inc;
	assign cmd.tail_one = (is_zero || blk_full) && item.frame_last;
	assign cmd.last     = item.frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (accept) begin
				if (close_now) begin
					cnt_q  <= '0;
					bank_q <= !bank_q;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (cmd_push) begin
				busy_q[bank_q] <= 1'b1;
			end
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
		end
	end
endmodule

FILE: hdl/cfe_back.sv
// back end: walks each release one byte a cycle while the result queue has room and packs result words
`timescale 1ns / 1ps
module cfe_back #(
	parameter int WORD_BYTES = 8,
	parameter int IW         = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cmd_empty,
	output logic                                       cmd_pop,
	input  cfe_pkg::cmd_t                              cmd,
	output logic [IW:0]                                ram_raddr,
	input  logic [7:0]                                 ram_rdata,
	output cfe_pkg::rel_t                              rel,
	output logic                                       res_push,
	output cfe_pkg::out_t                              res,
	input  logic [$clog2(cfe_pkg::OUTQ_DEPTH+1)-1:0]   resq_count
);
	import cfe_pkg::*;

	localparam int LW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
	localparam int QW = $clog2(OUTQ_DEPTH+1) + 1;

	logic          active_q;
	logic          cbank_q;
	logic [7:0]    clen_q;
	logic          ctail_q;
	logic          clast_q;
	logic [8:0]    pos_q;
	logic [LW-1:0] lane_q;
	logic [4:0]    wcnt_q;

	logic          v_s1;
	logic          from_ram_s1;
	logic [7:0]    const_s1;
	logic [LW-1:0] lane_s1;
	logic          flush_s1;
	logic          end_s1;
	logic          last_s1;
	logic [63:0]   acc_q;

	logic [8:0]    end_pos;
	logic [8:0]    pos_dec;
	logic          end_byte;
	logic          flush;
	logic          finish;
	logic [QW-1:0] pending;
	logic          issue;
	logic          load;
	logic [7:0]    byte_val;
	logic [63:0]   word_next;

	assign end_pos  = {1'b0, clen_q} + {8'd0, ctail_q};
	assign pos_dec  = pos_q - 9'd1;
	assign end_byte = (pos_q == end_pos);
	assign flush    = (lane_q == LW'(WORD_BYTES-1)) || end_byte;
	assign finish   = end_byte || (flush && (wcnt_q == 5'(MAX_RESULTS-1)));
	assign pending  = QW'(resq_count) + QW'(v_s1 && flush_s1);
	assign issue    = active_q && (!flush || (pending < QW'(OUTQ_DEPTH)));
	assign load     = !active_q && !cmd_empty;

	assign cmd_pop   = load;
	assign ram_raddr = {cbank_q, pos_dec[IW-1:0]};
	assign rel.valid = issue && finish;
	assign rel.bank  = cbank_q;

	always_comb begin
		byte_val  = from_ram_s1 ? ram_rdata : const_s1;
		word_next = acc_q;
		word_next[{lane_s1, 3'b000} +: 8] = byte_val;
	end

	assign res_push       = v_s1 && flush_s1;
	assign res.out_bytes  = word_next;
	assign res.byte_count = 4'(lane_s1) + 4'd1;
	assign res.run_last   = end_s1;
	assign res.frame_done = end_s1 && last_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			cbank_q <= cmd.bank;
			clen_q  <= cmd.len;
			ctail_q <= cmd.tail_one;
			clast_q <= cmd.last;
		end
		if (issue) begin
			from_ram_s1 <= (pos_q != 9'd0) && (pos_q <= {1'b0, clen_q});
			const_s1    <= (pos_q == 9'd0) ? clen_q + 8'd1 : CODE_ONE;
			lane_s1     <= lane_q;
			flush_s1    <= flush;
			end_s1      <= finish;
			last_s1     <= clast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			lane_q   <= '0;
			wcnt_q   <= '0;
			v_s1     <= 1'b0;
			acc_q    <= '0;
		end else begin
			v_s1 <= issue;
			if (v_s1) begin
				acc_q <= flush_s1 ? '0 : word_next;
			end
			if (load) begin
				active_q <= 1'b1;
				pos_q    <= '0;
				lane_q   <= '0;
				wcnt_q   <= '0;
			end else if (issue) begin
				if (finish) begin
					active_q <= 1'b0;
				end
				pos_q  <= pos_q + 9'd1;
				lane_q <= flush ? '0 : lane_q + LW'(1);
				wcnt_q <= wcnt_q + 5'(flush);
			end
		end
	end
endmodule

FILE: hdl/cobs_frame_encoder.sv
// top level of the streaming cobs frame encoder
`timescale 1ns / 1ps
// Raw frame bytes enter one per cycle; nonzero bytes are written into one of
// two block banks while a byte that closes a block (a zero, the block filling
// at MAX_BLOCK, or the frame's last byte) queues a release. The back end walks
// each release one byte per cycle out of the block ram while the result
// queue has room, and packs its bytes into words of WORD_BYTES bytes.
// Input stalls while the bank to be filled is still busy or the release queue is full.
// A frame ending right after a full block ends in a lone code byte of 1.
module cobs_frame_encoder #(
	parameter int MAX_BLOCK  = 254,
	parameter int WORD_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  cfe_pkg::in_t   item,
	input  logic           pop,
	output logic           empty,
	output cfe_pkg::out_t  result
);
	import cfe_pkg::*;

	localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int RAM_DEPTH = 2 ** (IW + 1);

	logic          ram_we;
	logic [IW:0]   ram_waddr;
	logic [7:0]    ram_wdata;
	logic [IW:0]   ram_raddr;
	logic [7:0]    ram_rdata;
	logic          cmd_push;
	cmd_t          cmd_in;
	cmd_t          cmd_out;
	logic          cmd_pop;
	logic          cmd_empty;
	logic          cmd_full;
	logic [$clog2(CMDQ_DEPTH+1)-1:0] cmd_count;
	rel_t          rel;
	logic          res_push;
	out_t          res;
	logic          resq_full;
	logic [$clog2(OUTQ_DEPTH+1)-1:0] resq_count;

	cfe_front #(
		.MAX_BLOCK (MAX_BLOCK),
		.IW        (IW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmdq_full (cmd_full),
		.rel       (rel)
	);

	cfe_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cfe_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wdata  (cmd_in),
		.rd_en  (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty),
		.full   (cmd_full),
		.count  (cmd_count)
	);

	cfe_back #(
		.WORD_BYTES (WORD_BYTES),
		.IW         (IW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd_out),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rel        (rel),
		.res_push   (res_push),
		.res        (res),
		.resq_count (resq_count)
	);

	cfe_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (OUTQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wdata  (res),
		.rd_en  (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (resq_full),
		.count  (resq_count)
	);

	// result queue space is reserved before a word is built; it never overflows
	logic unused_ok;
	assign unused_ok = resq_full ^ (cmd_count == '0);
endmodule

FILE: hdl/cfe_checker.sv
// port-level checks for the cobs frame encoder and their bind
`timescale 1ns / 1ps
module cfe_checker #(
	parameter int WORD_BYTES = 8
) (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input cfe_pkg::in_t  item,
	input logic          pop,
	input logic          empty,
	input cfe_pkg::out_t result
);
	import cfe_pkg::*;

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// a word that closes the frame also closes its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_done |-> result.run_last)
		else $error("frame_done without run_last");

	// words inside a run are full
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.run_last |-> result.byte_count == 4'(WORD_BYTES))
		else $error("partial word before end of run");

	// count is in range and unused bytes are zero
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.byte_count != 4'd0 && result.byte_count <= 4'(WORD_BYTES)
			&& (result.out_bytes >> {result.byte_count, 3'b000}) == 64'd0)
		else $error("bad byte count or dirty unused bytes");

	logic unused_in;
	assign unused_in = push ^ full ^ item.frame_last;
endmodule

bind cobs_frame_encoder cfe_checker #(
	.WORD_BYTES (WORD_BYTES)
) u_cfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
